>>> hdl/sprf_pkg.sv
// Shared constants, codes and types of the sprite animation frame unit.
`default_nettype none
package sprf_pkg;

	// Default sizes of the animation stores.
	localparam int NUM_ANIMS_DEF  = 16;
	localparam int MAX_FRAMES_DEF = 32;

	// Configuration register indexes.
	localparam logic [2:0] REG_SHEET_W = 3'd0;
	localparam logic [2:0] REG_SHEET_H = 3'd1;
	localparam logic [2:0] REG_PITCH_X = 3'd2;
	localparam logic [2:0] REG_PITCH_Y = 3'd3;
	localparam logic [2:0] REG_OFFS_X  = 3'd4;
	localparam logic [2:0] REG_OFFS_Y  = 3'd5;
	localparam logic [2:0] REG_TILE_W  = 3'd6;
	localparam logic [2:0] REG_TILE_H  = 3'd7;

	// Register reset values.
	localparam logic [12:0] RST_SHEET = 13'd256;
	localparam logic [12:0] RST_PITCH = 13'd16;
	localparam logic [12:0] RST_TILE  = 13'd16;

	// Command kinds of an input item.
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_SELECT = 2'd1;
	localparam logic [1:0] KIND_HEADER = 2'd2;
	localparam logic [1:0] KIND_FRAME  = 2'd3;

	// Datapath operations issued by the controller.
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_ACCEPT = 4'd1;
	localparam logic [3:0] OP_WRAP   = 4'd2;
	localparam logic [3:0] OP_MUL_T  = 4'd3;
	localparam logic [3:0] OP_DIV    = 4'd4;
	localparam logic [3:0] OP_CAP    = 4'd5;
	localparam logic [3:0] OP_MUL_P  = 4'd6;
	localparam logic [3:0] OP_OUT    = 4'd7;
	localparam logic [3:0] OP_FIN    = 4'd8;

	// Division steps of one tick, in order.
	localparam logic [3:0] STEP_IDX  = 4'd0;
	localparam logic [3:0] STEP_COLS = 4'd1;
	localparam logic [3:0] STEP_ROWS = 4'd2;
	localparam logic [3:0] STEP_X    = 4'd3;
	localparam logic [3:0] STEP_Y    = 4'd4;
	localparam logic [3:0] STEP_UL   = 4'd5;
	localparam logic [3:0] STEP_UR   = 4'd6;
	localparam logic [3:0] STEP_VT   = 4'd7;
	localparam logic [3:0] STEP_VB   = 4'd8;

	// Divider geometry.
	localparam int DVD_W = 48;
	localparam int DVS_W = 24;

	localparam logic [17:0] UV_MAX = 18'h3FFFF;

	// Controller to datapath.
	typedef struct packed {
		logic [3:0] op;
		logic [3:0] step;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic tick;
		logic hdr_ok;
		logic dur_zero;
		logic idx_ok;
		logic div_done;
		logic out_full;
	} stat_t;

	// One animation header.
	typedef struct packed {
		logic        loop;
		logic [5:0]  cnt;
		logic [23:0] dur;
	} hdr_t;

endpackage
`default_nettype wire

>>> hdl/sprf_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sprf_div import sprf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dvd,
	input  wire logic [DVS_W-1:0] dvs,
	input  wire logic [5:0]       iters,
	output logic                  done,
	output logic [DVD_W-1:0]      quot,
	output logic [DVS_W-1:0]      rem
);
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quot_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [5:0]       cnt_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             take;

	// Trial subtraction of the next remainder.
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= iters;
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == 6'd1;
			if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
		end
	end

	// Shift and subtract.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dvd;
			dvs_q  <= dvs;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (cnt_q != 6'd0) begin
			dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
			quot_q <= {quot_q[DVD_W-2:0], take};
			rem_q  <= take ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

>>> hdl/sprf_datapath.sv
// Datapath: registers, animation stores, frame memory, divider and result register.
`default_nettype none
module sprf_datapath import sprf_pkg::*; #(
	parameter int NUM_ANIMS  = NUM_ANIMS_DEF,
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] delta_time,
	input  wire logic [3:0]  anim_id,
	input  wire logic [4:0]  frame_slot,
	input  wire logic signed [15:0] frame_value,
	input  wire logic [5:0]  frame_count,
	input  wire logic [23:0] duration,
	input  wire logic        loop_flag,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [17:0]      u_left,
	output logic [17:0]      v_top,
	output logic [17:0]      u_right,
	output logic [17:0]      v_bottom,
	output logic             mirrored,
	input  wire cmd_t        cmd,
	output stat_t            stat
);
	localparam int HDR_AW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
	localparam int TAB_DEPTH = NUM_ANIMS * MAX_FRAMES;
	localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

	// Configuration registers.
	logic [12:0] sheet_w_q, sheet_h_q, pitch_x_q, pitch_y_q, tile_w_q, tile_h_q;
	logic [11:0] offs_x_q, offs_y_q;

	// Animation state.
	logic [NUM_ANIMS-1:0] hdr_valid_q;
	hdr_t                 hdr_q [NUM_ANIMS];
	logic [15:0]          tab_mem [TAB_DEPTH];
	logic [3:0]           cur_q;
	logic [31:0]          time_q;
	logic [1:0]           kind_q;
	logic [15:0]          delta_q;

	// Work registers of one tick.
	logic [37:0] prod_q;
	logic [15:0] entry_q;
	logic [12:0] cols_q, rows_q, x_q, y_q;
	logic [16:0] q1_q;
	logic [15:0] px_q, py_q;
	logic [17:0] ul_q, ur_q, vt_q, vb_q;
	logic        out_valid_q;

	// Divider connections.
	logic             div_start, div_done;
	logic [DVD_W-1:0] div_dvd, div_quot;
	logic [DVS_W-1:0] div_dvs, div_rem;
	logic [5:0]       div_iters;

	logic              accept, id_ok, slot_ok, cur_ok, neg;
	logic [HDR_AW-1:0] wr_hidx, cur_hidx;
	logic [TAB_AW-1:0] wr_addr, rd_addr;
	hdr_t              hdr_cur;
	logic [16:0]       mag;
	logic [15:0]       pxr, pyr;
	logic [25:0]       mul_x, mul_y;
	logic [32:0]       time_sum;
	logic [17:0]       uv_val;

	assign accept   = cmd.op == OP_ACCEPT;
	assign id_ok    = 32'(anim_id) < NUM_ANIMS;
	assign slot_ok  = 32'(frame_slot) < MAX_FRAMES;
	assign cur_ok   = 32'(cur_q) < NUM_ANIMS;
	assign wr_hidx  = HDR_AW'(anim_id);
	assign cur_hidx = HDR_AW'(cur_q);
	assign hdr_cur  = hdr_q[cur_hidx];
	assign wr_addr  = TAB_AW'(32'(anim_id) * MAX_FRAMES + 32'(frame_slot));
	assign rd_addr  = TAB_AW'(32'(cur_q) * MAX_FRAMES + 32'(div_quot[5:0]));

	// Tile index magnitude and mirror flag of the fetched entry.
	assign neg = entry_q[15];
	assign mag = neg ? 17'(17'h10000 - {1'b0, entry_q}) : {1'b0, entry_q};

	assign pxr      = px_q + {3'b0, tile_w_q};
	assign pyr      = py_q + {3'b0, tile_h_q};
	assign mul_x    = 26'(pitch_x_q) * 26'(x_q);
	assign mul_y    = 26'(pitch_y_q) * 26'(y_q);
	assign time_sum = {1'b0, time_q} + 33'(delta_q);

	// Saturated coordinate from the current quotient.
	always_comb begin
		if (div_quot[DVD_W-1:18] != '0) uv_val = UV_MAX;
		else uv_val = div_quot[17:0];
	end

	// Status to the controller.
	always_comb begin
		stat.tick     = kind_q == KIND_TICK;
		stat.hdr_ok   = cur_ok && hdr_valid_q[cur_hidx];
		stat.dur_zero = hdr_cur.dur == 24'd0;
		stat.idx_ok   = (div_quot[DVD_W-1:6] == '0) && (div_quot[5:0] < hdr_cur.cnt);
		stat.div_done = div_done;
		stat.out_full = out_valid_q;
	end

	// Operand selection for each division step.
	always_comb begin
		div_start = cmd.op == OP_DIV;
		case (cmd.step)
			STEP_COLS: begin
				div_dvd = {sheet_w_q, 35'b0}; div_dvs = {11'b0, pitch_x_q}; div_iters = 6'd13;
			end
			STEP_ROWS: begin
				div_dvd = {sheet_h_q, 35'b0}; div_dvs = {11'b0, pitch_y_q}; div_iters = 6'd13;
			end
			STEP_X: begin
				div_dvd = {mag, 31'b0}; div_dvs = {11'b0, cols_q}; div_iters = 6'd17;
			end
			STEP_Y: begin
				div_dvd = {q1_q, 31'b0}; div_dvs = {11'b0, rows_q}; div_iters = 6'd17;
			end
			STEP_UL: begin
				div_dvd = {px_q, 32'b0}; div_dvs = {11'b0, sheet_w_q}; div_iters = 6'd32;
			end
			STEP_UR: begin
				div_dvd = {pxr, 32'b0}; div_dvs = {11'b0, sheet_w_q}; div_iters = 6'd32;
			end
			STEP_VT: begin
				div_dvd = {py_q, 32'b0}; div_dvs = {11'b0, sheet_h_q}; div_iters = 6'd32;
			end
			STEP_VB: begin
				div_dvd = {pyr, 32'b0}; div_dvs = {11'b0, sheet_h_q}; div_iters = 6'd32;
			end
			default: begin
				div_dvd = {prod_q, 10'b0}; div_dvs = hdr_cur.dur; div_iters = 6'd38;
			end
		endcase
	end

	sprf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.iters  (div_iters),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sheet_w_q <= RST_SHEET; sheet_h_q <= RST_SHEET;
			pitch_x_q <= RST_PITCH; pitch_y_q <= RST_PITCH;
			offs_x_q  <= '0;        offs_y_q  <= '0;
			tile_w_q  <= RST_TILE;  tile_h_q  <= RST_TILE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHEET_W: sheet_w_q <= cfg_data;
				REG_SHEET_H: sheet_h_q <= cfg_data;
				REG_PITCH_X: pitch_x_q <= cfg_data;
				REG_PITCH_Y: pitch_y_q <= cfg_data;
				REG_OFFS_X:  offs_x_q  <= cfg_data[11:0];
				REG_OFFS_Y:  offs_y_q  <= cfg_data[11:0];
				REG_TILE_W:  tile_w_q  <= cfg_data;
				REG_TILE_H:  tile_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Header valid bits, current animation and elapsed time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_q <= '0;
			cur_q       <= '0;
			time_q      <= '0;
			kind_q      <= KIND_TICK;
		end else begin
			if (accept) begin
				kind_q <= kind;
				if (kind == KIND_HEADER && id_ok) hdr_valid_q[wr_hidx] <= 1'b1;
				if (kind == KIND_SELECT && anim_id != cur_q) begin
					cur_q  <= anim_id;
					time_q <= '0;
				end
			end
			if (cmd.op == OP_WRAP && hdr_cur.loop && time_q > 32'(hdr_cur.dur))
				time_q <= time_q - 32'(hdr_cur.dur);
			if (cmd.op == OP_FIN)
				time_q <= time_sum[32] ? '1 : time_sum[31:0];
		end
	end

	// Header contents.
	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= delta_time;
			if (kind == KIND_HEADER && id_ok) begin
				hdr_q[wr_hidx].loop <= loop_flag;
				hdr_q[wr_hidx].cnt  <= ({3'b0, frame_count} > 9'(MAX_FRAMES)) ?
					6'(MAX_FRAMES) : frame_count;
				hdr_q[wr_hidx].dur  <= duration;
			end
		end
	end

	// Frame table memory.
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_FRAME && id_ok && slot_ok)
			tab_mem[wr_addr] <= frame_value;
		if (cmd.op == OP_CAP && cmd.step == STEP_IDX)
			entry_q <= tab_mem[rd_addr];
	end

	// Products and captured quotients.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL_T) prod_q <= 38'(time_q) * 38'(hdr_cur.cnt);
		if (cmd.op == OP_MUL_P) begin
			px_q <= mul_x[15:0] + 16'(offs_x_q);
			py_q <= mul_y[15:0] + 16'(offs_y_q);
		end
		if (cmd.op == OP_CAP) begin
			case (cmd.step)
				STEP_COLS: cols_q <= (pitch_x_q == '0 || div_quot[12:0] == '0) ?
					13'd1 : div_quot[12:0];
				STEP_ROWS: rows_q <= (pitch_y_q == '0 || div_quot[12:0] == '0) ?
					13'd1 : div_quot[12:0];
				STEP_X: begin
					x_q  <= div_rem[12:0];
					q1_q <= div_quot[16:0];
				end
				STEP_Y:  y_q  <= div_rem[12:0];
				STEP_UL: ul_q <= (sheet_w_q == '0) ? UV_MAX : uv_val;
				STEP_UR: ur_q <= (sheet_w_q == '0) ? UV_MAX : uv_val;
				STEP_VT: vt_q <= (sheet_h_q == '0) ? UV_MAX : uv_val;
				STEP_VB: vb_q <= (sheet_h_q == '0) ? UV_MAX : uv_val;
				default: ;
			endcase
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	// Result payload, with left and right swapped for a mirrored tile.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			u_left   <= neg ? ur_q : ul_q;
			u_right  <= neg ? ul_q : ur_q;
			v_top    <= vt_q;
			v_bottom <= vb_q;
			mirrored <= neg;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

>>> hdl/sprf_ctrl.sv
// Controller state machine that sequences the datapath through one item.
`default_nettype none
module sprf_ctrl import sprf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_WRAP   = 4'd2;
	localparam logic [3:0] S_MULT   = 4'd3;
	localparam logic [3:0] S_DSTART = 4'd4;
	localparam logic [3:0] S_DWAIT  = 4'd5;
	localparam logic [3:0] S_MULP   = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q, state_d;
	logic [3:0] step_q, step_d;

	assign in_ready = state_q == S_IDLE;

	// Next state and datapath command.
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.tick) state_d = S_IDLE;
				else if (!stat.hdr_ok) state_d = S_FIN;
				else state_d = S_WRAP;
			end
			S_WRAP: begin
				cmd.op  = OP_WRAP;
				state_d = stat.dur_zero ? S_FIN : S_MULT;
			end
			S_MULT: begin
				cmd.op  = OP_MUL_T;
				step_d  = STEP_IDX;
				state_d = S_DSTART;
			end
			S_DSTART: begin
				cmd.op  = OP_DIV;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_CAP;
					if (step_q == STEP_IDX && !stat.idx_ok) begin
						state_d = S_FIN;
					end else if (step_q == STEP_Y) begin
						state_d = S_MULP;
					end else if (step_q == STEP_VB) begin
						state_d = S_OUT;
					end else begin
						step_d  = step_q + 4'd1;
						state_d = S_DSTART;
					end
				end
			end
			S_MULP: begin
				cmd.op  = OP_MUL_P;
				step_d  = STEP_UL;
				state_d = S_DSTART;
			end
			S_OUT: begin
				// Wait until the result register is free or being emptied.
				if (!stat.out_full || out_ready) begin
					cmd.op  = OP_OUT;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.op  = OP_FIN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STEP_IDX;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end
endmodule
`default_nettype wire

>>> hdl/sprite_animation_frame_unit.sv
// Top level of the sprite animation frame unit.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    kind .. loop_flag
// out      output     out_valid / out_ready  u_left, v_top, u_right, v_bottom, mirrored
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// A tick that finds a frame runs the shared one-bit-per-cycle divider through nine
// divisions in turn, and ends early when its animation has no header, a zero
// duration or no frame at its index. Reset loads the configuration registers with
// their defaults and clears the header valid bits, time and current animation; the
// frame memory is not cleared. A result waits in its register while out_ready is
// low; the next item is still taken, and a later tick stalls only to load its result.
`default_nettype none
module sprite_animation_frame_unit import sprf_pkg::*; #(
	parameter int NUM_ANIMS  = NUM_ANIMS_DEF,
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] delta_time,
	input  wire logic [3:0]  anim_id,
	input  wire logic [4:0]  frame_slot,
	input  wire logic signed [15:0] frame_value,
	input  wire logic [5:0]  frame_count,
	input  wire logic [23:0] duration,
	input  wire logic        loop_flag,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [17:0]      u_left,
	output logic [17:0]      v_top,
	output logic [17:0]      u_right,
	output logic [17:0]      v_bottom,
	output logic             mirrored
);
	cmd_t  cmd;
	stat_t stat;

	sprf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sprf_datapath #(
		.NUM_ANIMS  (NUM_ANIMS),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.delta_time  (delta_time),
		.anim_id     (anim_id),
		.frame_slot  (frame_slot),
		.frame_value (frame_value),
		.frame_count (frame_count),
		.duration    (duration),
		.loop_flag   (loop_flag),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.u_left      (u_left),
		.v_top       (v_top),
		.u_right     (u_right),
		.v_bottom    (v_bottom),
		.mirrored    (mirrored),
		.cmd         (cmd),
		.stat        (stat)
	);
endmodule
`default_nettype wire

>>> hdl/sprf_checker.sv
// Port-level assertions of the sprite animation frame unit and their binding.
`default_nettype none
module sprf_checker import sprf_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  kind,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [17:0] u_left,
	input wire logic [17:0] v_top,
	input wire logic [17:0] u_right,
	input wire logic [17:0] v_bottom,
	input wire logic        mirrored
);
	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(u_left) && $stable(v_top) &&
		$stable(u_right) && $stable(v_bottom) && $stable(mirrored))
		else $error("result payload changed while stalled");

	// Every input transfer is followed by a drop of in_ready while the unit is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// A new result only appears while a tick is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

	// A non-tick item does not produce a result in the next cycle.
	a_no_result_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != KIND_TICK && !out_valid |=> !out_valid)
		else $error("result from a non-tick item");
endmodule

bind sprite_animation_frame_unit sprf_checker u_sprf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.u_left    (u_left),
	.v_top     (v_top),
	.u_right   (u_right),
	.v_bottom  (v_bottom),
	.mirrored  (mirrored)
);
`default_nettype wire
